// File: src/typed_stream_slot_allocator_top_assert.svh
// Assertion macros for the slot allocator top level.
`ifndef TYPED_STREAM_SLOT_ALLOCATOR_TOP_ASSERT_SVH
`define TYPED_STREAM_SLOT_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define TSSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define TSSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/tssa_pkg.sv
package tssa_pkg;

  // Slot array geometry
  localparam int MAX_SLOTS    = 30;
  localparam int OWNER_WIDTH  = 8;
  localparam int OWNER_PORT_W = 8;
  localparam int SLOT_W       = 5;
  localparam int RANGE_W      = 6;
  localparam int IRQ_W        = 32;
  localparam int IRQ_GLOBAL_BIT = 31;

  // Configuration register widths and reset values
  localparam int IN_CNT_W    = 4;
  localparam int OUT_CNT_W   = 4;
  localparam int BIDIR_CNT_W = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 5;
  localparam logic [IN_CNT_W-1:0]    IN_CNT_RST    = 4'd4;
  localparam logic [OUT_CNT_W-1:0]   OUT_CNT_RST   = 4'd4;
  localparam logic [BIDIR_CNT_W-1:0] BIDIR_CNT_RST = 5'd0;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IN_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIDIR_COUNT = 2'd2;

  // Input function and kind codes
  localparam logic [1:0] FUNC_ALLOC    = 2'd0;
  localparam logic [1:0] FUNC_FREE     = 2'd1;
  localparam logic [1:0] FUNC_DISPATCH = 2'd2;
  localparam logic [1:0] KIND_INPUT    = 2'd0;
  localparam logic [1:0] KIND_OUTPUT   = 2'd1;
  localparam logic [1:0] KIND_BIDIR    = 2'd2;

  // Queue sizes
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PW    = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);
  localparam int RESQ_DEPTH = 2;
  localparam int RESQ_PW    = (RESQ_DEPTH > 1) ? $clog2(RESQ_DEPTH) : 1;
  localparam int RESQ_CW    = $clog2(RESQ_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_DISPATCH
  } op_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_NO_FREE,
    ST_NOT_ALLOC,
    ST_RANGE
  } status_t;

  // Classified command handed from front to back
  typedef struct packed {
    op_t                    op;
    logic [OWNER_WIDTH-1:0] owner;
    logic [SLOT_W-1:0]      slot;
    logic [MAX_SLOTS-1:0]   bits;   // candidate range for allocate, stream bits for dispatch
  } cmd_t;

  typedef struct packed {
    status_t                 status;
    logic [SLOT_W-1:0]       slot_index;
    logic [OWNER_PORT_W-1:0] slot_owner;
    logic                    last;
  } res_t;

  // Index of lowest set bit (0 when none set)
  function automatic logic [SLOT_W-1:0] find_first(input logic [MAX_SLOTS-1:0] v);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (v[i]) idx = SLOT_W'(i);
    end
    return idx;
  endfunction

endpackage

// File: src/tssa_front.sv
module tssa_front
  import tssa_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // config write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // input item
  input  logic                   in_push,
  input  logic [1:0]             in_func,
  input  logic [1:0]             in_stream_kind,
  input  logic [7:0]             in_owner_tag,
  input  logic [SLOT_W-1:0]      in_slot_number,
  input  logic [IRQ_W-1:0]       in_irq_status,
  // to command queue
  output logic                   cmd_push,
  output cmd_t                   cmd_data,
  input  logic                   cmd_full
);

  logic [IN_CNT_W-1:0]    in_cnt_r;
  logic [OUT_CNT_W-1:0]   out_cnt_r;
  logic [BIDIR_CNT_W-1:0] bidir_cnt_r;
  logic [RANGE_W-1:0]     lo;
  logic [RANGE_W-1:0]     hi;
  logic [RANGE_W-1:0]     io_end;
  logic [MAX_SLOTS-1:0]   range_mask;
  logic [MAX_SLOTS-1:0]   stream_bits;
  logic                   keep;

  assign cfg_ready = 1'b1;

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_cnt_r    <= IN_CNT_RST;
      out_cnt_r   <= OUT_CNT_RST;
      bidir_cnt_r <= BIDIR_CNT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_IN_COUNT:    in_cnt_r    <= cfg_data[IN_CNT_W-1:0];
        CFG_OUT_COUNT:   out_cnt_r   <= cfg_data[OUT_CNT_W-1:0];
        CFG_BIDIR_COUNT: bidir_cnt_r <= cfg_data[BIDIR_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Slot range of the requested kind
  assign io_end = RANGE_W'(in_cnt_r) + RANGE_W'(out_cnt_r);

  always_comb begin
    unique case (in_stream_kind)
      KIND_INPUT: begin
        lo = '0;
        hi = RANGE_W'(in_cnt_r);
      end
      KIND_OUTPUT: begin
        lo = RANGE_W'(in_cnt_r);
        hi = io_end;
      end
      KIND_BIDIR: begin
        lo = io_end;
        hi = io_end + RANGE_W'(bidir_cnt_r);
      end
      default: begin
        lo = '0;
        hi = '0;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      range_mask[i] = (RANGE_W'(i) >= lo) && (RANGE_W'(i) < hi);
    end
  end

  assign stream_bits = in_irq_status[MAX_SLOTS-1:0];

  // Classify; items that give no result are dropped here
  always_comb begin
    cmd_data.owner = in_owner_tag[OWNER_WIDTH-1:0];
    cmd_data.slot  = in_slot_number;
    cmd_data.op    = OP_ALLOC;
    cmd_data.bits  = range_mask;
    keep           = 1'b0;
    unique case (in_func)
      FUNC_ALLOC: begin
        keep = 1'b1;
      end
      FUNC_FREE: begin
        cmd_data.op = OP_FREE;
        keep        = 1'b1;
      end
      FUNC_DISPATCH: begin
        cmd_data.op   = OP_DISPATCH;
        cmd_data.bits = stream_bits;
        keep          = in_irq_status[IRQ_GLOBAL_BIT] && (|stream_bits);
      end
      default: keep = 1'b0;
    endcase
  end

  assign cmd_push = in_push && !cmd_full && keep;

endmodule

// File: src/tssa_cmd_q.sv
module tssa_cmd_q
  import tssa_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output cmd_t dout,
  output logic empty
);

  cmd_t               mem_r [CMDQ_DEPTH];
  logic [CMDQ_PW-1:0] wr_ptr_r;
  logic [CMDQ_PW-1:0] wr_ptr_nxt;
  logic [CMDQ_PW-1:0] rd_ptr_r;
  logic [CMDQ_PW-1:0] rd_ptr_nxt;
  logic [CMDQ_CW-1:0] cnt_r;
  logic [CMDQ_CW-1:0] cnt_nxt;
  logic               do_push;
  logic               do_pop;

  assign full    = (cnt_r == CMDQ_CW'(CMDQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == CMDQ_PW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == CMDQ_PW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= din;
  end

endmodule

// File: src/tssa_back.sv
module tssa_back
  import tssa_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  // from command queue
  input  cmd_t cmd_head,
  input  logic cmd_empty,
  output logic cmd_pop,
  // to result queue
  output logic res_push,
  output res_t res_data,
  input  logic res_full
);

  logic [MAX_SLOTS-1:0]   in_use_r;
  logic [MAX_SLOTS-1:0]   in_use_nxt;
  logic [OWNER_WIDTH-1:0] owner_mem_r [MAX_SLOTS];
  logic                   act_r;
  logic                   act_nxt;
  logic [MAX_SLOTS-1:0]   rem_r;
  logic [MAX_SLOTS-1:0]   rem_nxt;

  logic                   go;
  logic [MAX_SLOTS-1:0]   alloc_cand;
  logic                   alloc_hit;
  logic [SLOT_W-1:0]      alloc_idx;
  logic                   alloc_wr;
  logic                   free_in_range;
  logic                   free_used;
  logic [MAX_SLOTS-1:0]   disp_bits;
  logic [SLOT_W-1:0]      disp_idx;
  logic [MAX_SLOTS-1:0]   disp_rem;
  logic                   disp_last;
  logic [SLOT_W-1:0]      rd_idx;
  logic [OWNER_WIDTH-1:0] rd_owner;

  assign go = !cmd_empty && !res_full;

  // Allocate: lowest free slot in the kind's range
  assign alloc_cand = cmd_head.bits & ~in_use_r;
  assign alloc_hit  = |alloc_cand;
  assign alloc_idx  = find_first(alloc_cand);

  // Free: range and in-use check
  assign free_in_range = (cmd_head.slot < SLOT_W'(MAX_SLOTS));
  assign free_used     = free_in_range && in_use_r[cmd_head.slot];

  // Dispatch: one set stream bit per cycle while the result queue has room
  assign disp_bits = act_r ? rem_r : cmd_head.bits;
  assign disp_idx  = find_first(disp_bits);
  assign disp_rem  = disp_bits & ~(MAX_SLOTS'(1) << disp_idx);
  assign disp_last = (disp_rem == '0);

  // Single owner read port
  assign rd_idx   = (cmd_head.op == OP_DISPATCH) ? disp_idx : cmd_head.slot;
  assign rd_owner = owner_mem_r[rd_idx];

  // Execute head command
  always_comb begin
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    alloc_wr   = 1'b0;
    in_use_nxt = in_use_r;
    act_nxt    = act_r;
    rem_nxt    = rem_r;
    res_data   = '{status: ST_OK, slot_index: '0, slot_owner: '0, last: 1'b1};
    if (go) begin
      unique case (cmd_head.op)
        OP_ALLOC: begin
          cmd_pop  = 1'b1;
          res_push = 1'b1;
          if (alloc_hit) begin
            alloc_wr              = 1'b1;
            in_use_nxt[alloc_idx] = 1'b1;
            res_data.slot_index   = alloc_idx;
            res_data.slot_owner   = OWNER_PORT_W'(cmd_head.owner);
          end else begin
            res_data.status = ST_NO_FREE;
          end
        end
        OP_FREE: begin
          cmd_pop  = 1'b1;
          res_push = 1'b1;
          if (!free_in_range) begin
            res_data.status = ST_RANGE;
          end else if (!free_used) begin
            res_data.status     = ST_NOT_ALLOC;
            res_data.slot_index = cmd_head.slot;
          end else begin
            in_use_nxt[cmd_head.slot] = 1'b0;
            res_data.slot_index       = cmd_head.slot;
            res_data.slot_owner       = OWNER_PORT_W'(rd_owner);
          end
        end
        OP_DISPATCH: begin
          res_push            = 1'b1;
          res_data.slot_index = disp_idx;
          res_data.last       = disp_last;
          if (in_use_r[disp_idx]) begin
            res_data.slot_owner = OWNER_PORT_W'(rd_owner);
          end else begin
            res_data.status = ST_NOT_ALLOC;
          end
          if (disp_last) begin
            cmd_pop = 1'b1;
            act_nxt = 1'b0;
          end else begin
            act_nxt = 1'b1;
            rem_nxt = disp_rem;
          end
        end
        default: cmd_pop = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= '0;
      act_r    <= 1'b0;
    end else begin
      in_use_r <= in_use_nxt;
      act_r    <= act_nxt;
    end
  end

  // Remaining dispatch bits and owner store
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    if (alloc_wr) owner_mem_r[alloc_idx] <= cmd_head.owner;
  end

endmodule

// File: src/tssa_res_q.sv
module tssa_res_q
  import tssa_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t din,
  output logic full,
  input  logic pop,
  output res_t dout,
  output logic empty
);

  res_t               mem_r [RESQ_DEPTH];
  logic [RESQ_PW-1:0] wr_ptr_r;
  logic [RESQ_PW-1:0] wr_ptr_nxt;
  logic [RESQ_PW-1:0] rd_ptr_r;
  logic [RESQ_PW-1:0] rd_ptr_nxt;
  logic [RESQ_CW-1:0] cnt_r;
  logic [RESQ_CW-1:0] cnt_nxt;
  logic               do_push;
  logic               do_pop;

  assign full    = (cnt_r == RESQ_CW'(RESQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == RESQ_PW'(RESQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == RESQ_PW'(RESQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= din;
  end

endmodule

// File: src/typed_stream_slot_allocator_top.sv
// A result reaches the out_ ports after its item is written into the command queue,
// executed by the back end and written into the result queue; the back end stalls
// while the result queue is full. Allocate and free are single steps; dispatch gives
// one result per set stream bit, lowest first, from the single lowest-bit search.
// Reset (rst_n low, synchronous): both queues empty, all slots free, slot counts 4/4/0.
// The owner store is not cleared; there is no clearing pass.
`include "typed_stream_slot_allocator_top_assert.svh"

module typed_stream_slot_allocator_top
  import tssa_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  // configuration
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  // input items
  input  logic                    in_push,
  output logic                    in_full,
  input  logic [1:0]              in_func,
  input  logic [1:0]              in_stream_kind,
  input  logic [7:0]              in_owner_tag,
  input  logic [SLOT_W-1:0]       in_slot_number,
  input  logic [IRQ_W-1:0]        in_irq_status,
  // results
  output logic                    out_empty,
  input  logic                    out_pop,
  output logic [1:0]              out_status,
  output logic [SLOT_W-1:0]       out_slot_index,
  output logic [OWNER_PORT_W-1:0] out_slot_owner,
  output logic                    out_last
);

  cmd_t cmd_in;
  cmd_t cmd_head;
  logic cmd_push;
  logic cmd_full;
  logic cmd_pop;
  logic cmd_empty;
  res_t res_in;
  res_t res_head;
  logic res_push;
  logic res_full;
  logic out_idx_ok;
  logic out_mid_ok;

  assign in_full = cmd_full;

  // Front: config and classification
  tssa_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_push        (in_push),
    .in_func        (in_func),
    .in_stream_kind (in_stream_kind),
    .in_owner_tag   (in_owner_tag),
    .in_slot_number (in_slot_number),
    .in_irq_status  (in_irq_status),
    .cmd_push       (cmd_push),
    .cmd_data       (cmd_in),
    .cmd_full       (cmd_full)
  );

  // Command queue between front and back
  tssa_cmd_q u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_head),
    .empty (cmd_empty)
  );

  // Back: slot state and execution
  tssa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_head  (cmd_head),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res_data  (res_in),
    .res_full  (res_full)
  );

  // Result queue
  tssa_res_q u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (res_head),
    .empty (out_empty)
  );

  assign out_status     = res_head.status;
  assign out_slot_index = res_head.slot_index;
  assign out_slot_owner = res_head.slot_owner;
  assign out_last       = res_head.last;

  // Terms for the checks
  assign out_idx_ok = (out_slot_index < SLOT_W'(MAX_SLOTS));
  assign out_mid_ok = (out_status == ST_OK) || (out_status == ST_NOT_ALLOC);

  // Checks
  `TSSA_ASSERT_NOW(a_res_push_room, res_push, !res_full, "result pushed into full queue")
  `TSSA_ASSERT_NOW(a_cmd_pop_valid, cmd_pop, !cmd_empty, "command popped from empty queue")
  `TSSA_ASSERT_NOW(a_slot_in_range, !out_empty, out_idx_ok, "slot index out of range")
  `TSSA_ASSERT_NOW(a_mid_is_dispatch, !out_empty && !out_last, out_mid_ok, "non-last result with bad status")

endmodule
